[rtl/timed_multichannel_pump_sequencer_macros.svh]
// Assertion macros shared by the pump sequencer checker.
`ifndef TIMED_MULTICHANNEL_PUMP_SEQUENCER_MACROS_SVH
`define TIMED_MULTICHANNEL_PUMP_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TMPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TMPS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tmps_pkg.sv]
// Shared types and constants of the pump sequencer.
package tmps_pkg;

  localparam int OPCODE_W      = 3;
  localparam int SLOT_W        = 4;
  localparam int PUMP_ID_W     = 5;
  localparam int DURATION_W    = 16;
  localparam int COUNT_W       = 5;
  localparam int FAULT_GROUP_W = 2;
  localparam int PUMP_MASK_W   = 20;
  localparam int STATUS_W      = 3;

  localparam logic [DURATION_W-1:0] TICK_LIMIT = 16'hFFFF;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD      = 3'd0,
    OP_START     = 3'd1,
    OP_TICK      = 3'd2,
    OP_CLEAN_ON  = 3'd3,
    OP_CLEAN_OFF = 3'd4,
    OP_PUMP_ON   = 3'd5,
    OP_PUMP_OFF  = 3'd6,
    OP_FAULT     = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BUSY     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BAD_PUMP = 3'd3,
    ST_BAD_TIME = 3'd4,
    ST_NOT_RUN  = 3'd5
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_OUT
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_step;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_scan;
    logic scan_end;
  } dp_stat_t;

endpackage

[rtl/tmps_if.sv]
// Request and result channel interfaces of the pump sequencer.
interface tmps_req_if;
  import tmps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OPCODE_W-1:0]      opcode;
  logic [SLOT_W-1:0]        slot;
  logic [PUMP_ID_W-1:0]     pump_id;
  logic [DURATION_W-1:0]    duration;
  logic [COUNT_W-1:0]       recipe_count;
  logic [FAULT_GROUP_W-1:0] fault_group;

  modport source (output valid, opcode, slot, pump_id, duration, recipe_count, fault_group,
                  input ready);
  modport sink   (input valid, opcode, slot, pump_id, duration, recipe_count, fault_group,
                  output ready);
endinterface

interface tmps_rsp_if;
  import tmps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [PUMP_MASK_W-1:0] pump_mask;
  logic                   running;
  logic [STATUS_W-1:0]    status;
  logic                   recipe_done;

  modport source (output valid, pump_mask, running, status, recipe_done, input ready);
  modport sink   (input valid, pump_mask, running, status, recipe_done, output ready);
endinterface

[rtl/tmps_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tmps_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tmps_ctrl.sv]
// Controller state machine of the pump sequencer.
module tmps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tmps_pkg::dp_stat_t stat,
  output tmps_pkg::ctrl_cmd_t cmd
);
  import tmps_pkg::*;

  ctrl_state_t state, state_next;
  logic        load_out;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: state_next = stat.need_scan ? S_SCAN : S_OUT;
      S_SCAN:   if (stat.scan_end) state_next = S_OUT;
      S_OUT:    if (load_out) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    load_out      = (state == S_OUT) && (!out_valid || out_ready);
    in_ready      = (state == S_IDLE);
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.exec      = (state == S_DECODE);
    cmd.scan_step = (state == S_SCAN);
    cmd.load_out  = load_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // hold the result until taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/tmps_dp.sv]
// Datapath of the pump sequencer: item registers, recipe RAM, pump state, result register.
module tmps_dp #(
  parameter int MAX_ENTRIES = 16,
  parameter int NUM_PUMPS   = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tmps_pkg::ctrl_cmd_t                 cmd,
  output tmps_pkg::dp_stat_t                  stat,
  input  logic [tmps_pkg::OPCODE_W-1:0]       opcode,
  input  logic [tmps_pkg::SLOT_W-1:0]         slot,
  input  logic [tmps_pkg::PUMP_ID_W-1:0]      pump_id,
  input  logic [tmps_pkg::DURATION_W-1:0]     duration,
  input  logic [tmps_pkg::COUNT_W-1:0]        recipe_count,
  output logic [tmps_pkg::PUMP_MASK_W-1:0]    pump_mask,
  output logic                                running,
  output logic [tmps_pkg::STATUS_W-1:0]       status,
  output logic                                recipe_done
);
  import tmps_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int WD = PUMP_ID_W + DURATION_W;

  function automatic logic pump_ok(input logic [PUMP_ID_W-1:0] id);
    pump_ok = (id != '0) && (32'(id) <= NUM_PUMPS);
  endfunction

  function automatic logic [NUM_PUMPS-1:0] pump_bit(input logic [PUMP_ID_W-1:0] id);
    logic [PUMP_ID_W-1:0] sh;
    sh = id - 1'b1;
    pump_bit = NUM_PUMPS'(1) << sh;
  endfunction

  // Item registers
  op_t                   op_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [PUMP_ID_W-1:0]  pid_q;
  logic [DURATION_W-1:0] dur_q;
  logic [CW-1:0]         cnt_q;

  // Block state
  logic [NUM_PUMPS-1:0]   drive, drive_next;
  logic [MAX_ENTRIES-1:0] active, active_next;
  logic                   busy, busy_next;
  logic                   recipe, recipe_next;
  logic [DURATION_W-1:0]  elapsed, elapsed_next;

  // Scan and per-item working registers
  logic [CW-1:0]         chk_idx, chk_next;
  logic [CW-1:0]         scan_lim, scan_lim_next;
  logic [NUM_PUMPS-1:0]  tmp_mask, tmp_next;
  logic                  left, left_next;
  stat_t                 stat_q, stat_next;
  logic                  done_q, done_next;

  logic [CW-1:0]         chk_inc;
  logic [AW-1:0]         raddr;
  logic                  ram_we;
  logic [WD-1:0]         rdata;
  logic [PUMP_ID_W-1:0]  rd_pump;
  logic [DURATION_W-1:0] rd_dead;
  logic                  slot_ok;
  logic                  bad_pump;
  logic                  bad_time;
  logic                  scan_last;
  logic                  remain;
  logic [31:0]           drive32;

  assign chk_inc   = chk_idx + 1'b1;
  assign raddr     = cmd.exec ? '0 : chk_inc[AW-1:0];
  assign slot_ok   = 32'(slot_q) < MAX_ENTRIES;
  assign ram_we    = cmd.exec && (op_q == OP_LOAD) && !busy && slot_ok;
  assign rd_pump   = rdata[WD-1 -: PUMP_ID_W];
  assign rd_dead   = rdata[DURATION_W-1:0];
  assign bad_pump  = !pump_ok(rd_pump);
  assign bad_time  = (rd_dead == '0);
  assign scan_last = (chk_inc == scan_lim);
  assign remain    = active[chk_idx[AW-1:0]] && (rd_dead > elapsed);
  assign drive32   = 32'(drive);

  assign stat.need_scan = ((op_q == OP_START) && !busy && (cnt_q != '0)) ||
                          ((op_q == OP_TICK) && recipe);
  assign stat.scan_end  = scan_last || ((op_q == OP_START) && (bad_pump || bad_time));

  // Recipe entries: pump id over deadline
  tmps_ram #(
    .WIDTH (WD),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(slot_q)),
    .wdata ({pid_q, dur_q}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Execute the item and step the entry scan
  always_comb begin
    drive_next    = drive;
    active_next   = active;
    busy_next     = busy;
    recipe_next   = recipe;
    elapsed_next  = elapsed;
    chk_next      = chk_idx;
    scan_lim_next = scan_lim;
    tmp_next      = tmp_mask;
    left_next     = left;
    stat_next     = stat_q;
    done_next     = done_q;

    if (cmd.exec) begin
      done_next     = 1'b0;
      stat_next     = ST_OK;
      chk_next      = '0;
      tmp_next      = '0;
      left_next     = 1'b0;
      scan_lim_next = cnt_q;
      unique case (op_q)
        OP_LOAD: begin
          if (busy) stat_next = ST_BUSY;
        end
        OP_START: begin
          if (busy) begin
            stat_next = ST_BUSY;
          end else if (cnt_q == '0) begin
            stat_next = ST_EMPTY;
          end
        end
        OP_TICK: begin
          scan_lim_next = CW'(MAX_ENTRIES);
          if (!recipe) begin
            stat_next = ST_NOT_RUN;
          end else if (elapsed != TICK_LIMIT) begin
            elapsed_next = elapsed + 1'b1;
          end
        end
        OP_CLEAN_ON: begin
          if (busy) begin
            stat_next = ST_BUSY;
          end else begin
            busy_next   = 1'b1;
            recipe_next = 1'b0;
            drive_next  = '1;
          end
        end
        OP_CLEAN_OFF: begin
          if (!busy) begin
            stat_next = ST_NOT_RUN;
          end else begin
            drive_next  = '0;
            busy_next   = 1'b0;
            recipe_next = 1'b0;
            active_next = '0;
          end
        end
        OP_PUMP_ON, OP_PUMP_OFF: begin
          if (!pump_ok(pid_q)) begin
            stat_next = ST_BAD_PUMP;
          end else if (op_q == OP_PUMP_ON) begin
            drive_next = drive | pump_bit(pid_q);
          end else begin
            drive_next = drive & ~pump_bit(pid_q);
          end
        end
        OP_FAULT: begin
          drive_next  = '0;
          busy_next   = 1'b0;
          recipe_next = 1'b0;
          active_next = '0;
        end
        default: ;
      endcase
    end

    if (cmd.scan_step) begin
      chk_next = chk_inc;
      if (op_q == OP_START) begin
        // validate in slot order, pump before duration
        if (bad_pump) begin
          stat_next = ST_BAD_PUMP;
        end else if (bad_time) begin
          stat_next = ST_BAD_TIME;
        end else if (scan_last) begin
          drive_next   = drive | tmp_mask | pump_bit(rd_pump);
          busy_next    = 1'b1;
          recipe_next  = 1'b1;
          elapsed_next = '0;
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            active_next[i] = CW'(i) < cnt_q;
          end
        end else begin
          tmp_next = tmp_mask | pump_bit(rd_pump);
        end
      end else begin
        // drop every entry whose deadline has been reached
        if (active[chk_idx[AW-1:0]] && !remain) begin
          drive_next                  = drive & ~pump_bit(rd_pump);
          active_next[chk_idx[AW-1:0]] = 1'b0;
        end
        left_next = left || remain;
        if (scan_last && !(left || remain)) begin
          busy_next   = 1'b0;
          recipe_next = 1'b0;
          done_next   = 1'b1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      drive   <= '0;
      active  <= '0;
      busy    <= 1'b0;
      recipe  <= 1'b0;
      elapsed <= '0;
    end else begin
      drive   <= drive_next;
      active  <= active_next;
      busy    <= busy_next;
      recipe  <= recipe_next;
      elapsed <= elapsed_next;
    end
  end

  // Item capture, scan registers and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op_t'(opcode);
      slot_q <= slot;
      pid_q  <= pump_id;
      dur_q  <= duration;
      cnt_q  <= (32'(recipe_count) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(recipe_count);
    end
    chk_idx  <= chk_next;
    scan_lim <= scan_lim_next;
    tmp_mask <= tmp_next;
    left     <= left_next;
    stat_q   <= stat_next;
    done_q   <= done_next;
    if (cmd.load_out) begin
      pump_mask   <= drive32[PUMP_MASK_W-1:0];
      running     <= busy;
      status      <= stat_q;
      recipe_done <= done_q;
    end
  end

endmodule

[rtl/timed_multichannel_pump_sequencer.sv]
// Top level of the timed multichannel pump sequencer.
//
//  channel | dir | payload                                                  | handshake
//  req     | in  | opcode slot pump_id duration recipe_count fault_group     | valid/ready
//  rsp     | out | pump_mask running status recipe_done                     | valid/ready
//
// One item at a time: accept, execute, load the result register; the result is offered
// from the output register, and the next item can be accepted once that register is loaded.
// Start and tick also scan entries through the RAM read port: the recipe count for a
// start (ending early at the first bad entry), MAX_ENTRIES for a tick in a recipe; a
// refused start or tick scans nothing.
// Reset clears the pump drive, active entries, busy and recipe flags and elapsed time;
// recipe RAM contents are not cleared. A result waits in the output register while the
// next item is accepted; a stalled result holds the block before its next result.
module timed_multichannel_pump_sequencer #(
  parameter int MAX_ENTRIES = 16,
  parameter int NUM_PUMPS   = 20
) (
  input  logic      clk,
  input  logic      rst,
  tmps_req_if.sink  req,
  tmps_rsp_if.source rsp
);
  import tmps_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tmps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmps_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .NUM_PUMPS   (NUM_PUMPS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (req.opcode),
    .slot         (req.slot),
    .pump_id      (req.pump_id),
    .duration     (req.duration),
    .recipe_count (req.recipe_count),
    .pump_mask    (rsp.pump_mask),
    .running      (rsp.running),
    .status       (rsp.status),
    .recipe_done  (rsp.recipe_done)
  );

endmodule

[rtl/tmps_checker.sv]
// Port-level assertions of the pump sequencer and their bind.
`include "timed_multichannel_pump_sequencer_macros.svh"

module tmps_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [tmps_pkg::PUMP_MASK_W-1:0] rsp_pump_mask,
  input logic                             rsp_running,
  input logic [tmps_pkg::STATUS_W-1:0]    rsp_status,
  input logic                             rsp_recipe_done
);
  import tmps_pkg::*;

  // A stalled result holds
  `TMPS_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pump_mask) && $stable(rsp_status), "stalled result changed")

  // One item in flight: no accept right after an accept
  `TMPS_ASSERT_NXT(a_one_item, clk, rst, req_valid && req_ready, !req_ready, "item accepted while busy")

  // The ending tick is ok and leaves the block idle
  `TMPS_ASSERT_IMP(a_done_idle, clk, rst, rsp_valid && rsp_recipe_done, !rsp_running && (rsp_status == ST_OK), "recipe end inconsistent")

  // A refusal for busy leaves the block running
  `TMPS_ASSERT_IMP(a_busy_run, clk, rst, rsp_valid && (rsp_status == ST_BUSY), rsp_running, "busy status while idle")

endmodule

bind timed_multichannel_pump_sequencer tmps_checker u_tmps_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_pump_mask   (rsp.pump_mask),
  .rsp_running     (rsp.running),
  .rsp_status      (rsp.status),
  .rsp_recipe_done (rsp.recipe_done)
);
